>>> sv/udiv256_pkg.sv
`timescale 1ns / 1ps

package udiv256_pkg;

   localparam int WORD_WIDTH  = 64;
   localparam int WORD_COUNT  = 4;
   localparam int DATA_WIDTH  = WORD_WIDTH * WORD_COUNT;
   localparam int COUNT_WIDTH = $clog2(DATA_WIDTH);

   // Index of the final shift-subtract iteration.
   localparam logic [COUNT_WIDTH-1:0] LAST_STEP = COUNT_WIDTH'(DATA_WIDTH - 1);

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic den_zero;
   } dp_status_type;

endpackage

>>> sv/unsigned_divider_256_top.sv
// A beat accepted while idle runs 256 shift-subtract iterations, one per cycle,
// and then shows its result. A zero divisor skips the iterations and its
// result follows in the next cycle. One division runs at a time; busy stays
// high until the result has been shown. The receiver cannot stall, so the
// result strobe lasts one cycle. Reset is synchronous, active high, and
// returns the control to idle.
`timescale 1ns / 1ps

module unsigned_divider_256_top
   import udiv256_pkg::*;
(
   input  logic     clock,
   input  logic     reset,

   input  logic     start,
   output logic     busy,
   input  word_type req_dividend_w0,
   input  word_type req_dividend_w1,
   input  word_type req_dividend_w2,
   input  word_type req_dividend_w3,
   input  word_type req_divisor_w0,
   input  word_type req_divisor_w1,
   input  word_type req_divisor_w2,
   input  word_type req_divisor_w3,

   output logic     rsp_valid,
   output word_type rsp_quotient_w0,
   output word_type rsp_quotient_w1,
   output word_type rsp_quotient_w2,
   output word_type rsp_quotient_w3,
   output word_type rsp_remainder_w0,
   output word_type rsp_remainder_w1,
   output word_type rsp_remainder_w2,
   output word_type rsp_remainder_w3,
   output logic     rsp_divide_by_zero
);

   // The controller sequences one division at a time: it loads the operands
   // when a beat is accepted, runs the datapath for one restoring
   // shift-subtract iteration per cycle, and raises the result strobe for a
   // single cycle once the last quotient bit is in place.
   dp_cmd_type    cmd;
   dp_status_type status;

   data_type dividend;
   data_type divisor;
   data_type quotient;
   data_type remainder;

   // Words travel least significant first, so word 3 is the top of the value.
   assign dividend = {req_dividend_w3, req_dividend_w2, req_dividend_w1, req_dividend_w0};
   assign divisor  = {req_divisor_w3, req_divisor_w2, req_divisor_w1, req_divisor_w0};

   udiv256_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the partial remainder, the combined dividend and
   // quotient shift register and the divisor. A zero divisor is caught at
   // load time, when the dividend goes straight into the remainder.
   udiv256_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .dividend       (dividend),
      .divisor        (divisor),
      .quotient       (quotient),
      .remainder      (remainder),
      .divide_by_zero (rsp_divide_by_zero)
   );

   // The result registers stay stable while the strobe is high, so the
   // result ports are taken directly from them.
   assign rsp_quotient_w0  = quotient[0*WORD_WIDTH +: WORD_WIDTH];
   assign rsp_quotient_w1  = quotient[1*WORD_WIDTH +: WORD_WIDTH];
   assign rsp_quotient_w2  = quotient[2*WORD_WIDTH +: WORD_WIDTH];
   assign rsp_quotient_w3  = quotient[3*WORD_WIDTH +: WORD_WIDTH];
   assign rsp_remainder_w0 = remainder[0*WORD_WIDTH +: WORD_WIDTH];
   assign rsp_remainder_w1 = remainder[1*WORD_WIDTH +: WORD_WIDTH];
   assign rsp_remainder_w2 = remainder[2*WORD_WIDTH +: WORD_WIDTH];
   assign rsp_remainder_w3 = remainder[3*WORD_WIDTH +: WORD_WIDTH];

   a_dbz_quotient_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (quotient == '0))
      else $error("divide-by-zero beat carries a non-zero quotient");

endmodule

>>> sv/udiv256_ctrl.sv
`timescale 1ns / 1ps

module udiv256_ctrl
   import udiv256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   count_type count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               count_in = '0;
               // A zero divisor needs no iterations at all.
               state_in = status.den_zero ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid) || (rsp_valid && $past(status.den_zero)))
      else $error("accepted beat did not make the block busy");

endmodule

>>> sv/udiv256_dp.sv
`timescale 1ns / 1ps

module udiv256_dp
   import udiv256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  data_type      dividend,
   input  data_type      divisor,
   output data_type      quotient,
   output data_type      remainder,
   output logic          divide_by_zero
);

   // The quotient register starts out holding the dividend; each step shifts
   // a dividend bit out at the top and a quotient bit in at the bottom.
   data_type rem_ff, rem_in;
   data_type quo_ff, quo_in;
   data_type den_ff, den_in;
   logic     dbz_ff, dbz_in;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH+1:0] trial;
   logic                  fits;

   assign status.den_zero = (divisor == '0);

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = !trial[DATA_WIDTH+1];

      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      dbz_in = dbz_ff;
      priority if (cmd.load) begin
         den_in = divisor;
         dbz_in = status.den_zero;
         if (status.den_zero) begin
            rem_in = dividend;
            quo_in = '0;
         end else begin
            rem_in = '0;
            quo_in = dividend;
         end
      end else if (cmd.step) begin
         rem_in = fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
      end else begin
         // Neither command: every register holds.
         den_in = den_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      dbz_ff <= dbz_in;
   end

   assign quotient       = quo_ff;
   assign remainder      = rem_ff;
   assign divide_by_zero = dbz_ff;

   a_step_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (den_ff != '0))
      else $error("iteration started with a zero divisor");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.step) && !cmd.step && !dbz_ff |-> (rem_ff < den_ff))
      else $error("final remainder not below divisor");

endmodule
